/* hw/rtl/level_order_store_search_assert.svh */
// ----------------------------------------------------------------------------
// Level-order store search: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LEVEL_ORDER_STORE_SEARCH_ASSERT_SVH
`define LEVEL_ORDER_STORE_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LOS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LOS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/los_pkg.sv */
// ----------------------------------------------------------------------------
// Level-order store search: package
// Transaction payload types, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package los_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 9;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_SEARCH = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_SCAN = 3'b010,
		FSM_SUCC = 3'b100
	} fsm_t;

	typedef struct packed {
		kind_t                      kind;
		logic signed [VALUE_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		status_t                    status;
		logic [POS_W-1:0]           position;
		logic                       has_pred;
		logic signed [VALUE_W-1:0]  pred_value;
		logic                       has_succ;
		logic signed [VALUE_W-1:0]  succ_value;
		logic [POS_W-1:0]           node_count;
	} out_item_t;

endpackage

/* hw/rtl/los_chan_if.sv */
// ----------------------------------------------------------------------------
// Level-order store search: channel interface
// Valid/ready channel; a transaction moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface los_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/los_ram.sv */
// ----------------------------------------------------------------------------
// Level-order store search: generic single-port RAM
// One address per cycle, synchronous write, registered read data.
// ----------------------------------------------------------------------------
module los_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

/* hw/rtl/level_order_store_search.sv */
// ----------------------------------------------------------------------------
// Level-order store search: top level
// Append-only value store with first-match search and neighbor readout.
// ----------------------------------------------------------------------------
// The store holds up to CAPACITY signed Q16.16 values in one single-port RAM
// in insertion (level) order, plus a fill count; no clearing pass is needed
// after reset because only entries below the count are ever used. An insert
// writes the RAM at the count and returns its result in the next cycle, as
// does a dropped insert (store full). A search reads the RAM one entry per
// cycle from the first entry: a match is reported once the matching entry
// is compared, with an extra FSM_SUCC state when a successor exists, and
// a miss once every entry is compared; an empty store answers without a
// scan. The single RAM read port sets that pace. One transaction is in
// flight at a time; the next input is taken as soon as the controller is
// idle and the result register is free or being drained.
// ----------------------------------------------------------------------------
`include "level_order_store_search_assert.svh"

module level_order_store_search
	import los_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	los_chan_if.sink    req,
	los_chan_if.source  rsp
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	// Control state
	fsm_t          state_q;
	logic [CW-1:0] cnt_q;
	logic          rsp_valid_q;

	// Payload state
	logic [AW-1:0]              idx_q;    // index of the entry whose data is on rd_data
	logic signed [VALUE_W-1:0]  key_q;
	logic signed [VALUE_W-1:0]  prev_q;   // entry just before idx_q
	out_item_t                  rsp_q;

	// Handshake and scan helpers
	logic                       req_acc;
	logic                       rsp_acc;
	logic                       full;
	logic [CW-1:0]              idx_inc;
	logic                       has_next;
	logic                       is_match;

	// RAM port
	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic [VALUE_W-1:0]         rd_data;

	function automatic out_item_t plain_rsp(status_t st, logic [POS_W-1:0] pos,
			logic [POS_W-1:0] nodes);
		out_item_t r;
		r = '0;
		r.status     = st;
		r.position   = pos;
		r.node_count = nodes;
		return r;
	endfunction

	// Accept only when idle and the result slot is free by the next edge, so
	// every finishing transaction finds the output register empty.
	assign req.ready = (state_q == FSM_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_acc   = req.valid && req.ready;
	assign rsp_acc   = rsp.valid && rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign full     = (cnt_q == CW'(CAPACITY));
	assign idx_inc  = CW'(idx_q) + CW'(1);
	assign has_next = (idx_inc != cnt_q);
	assign is_match = (rd_data == key_q);

	// Write at the count on insert; start a search at entry 0; while scanning,
	// always prefetch the entry after the one being compared (it is the
	// successor on a match, the next candidate otherwise).
	assign ram_we = req_acc && (req.payload.kind == KIND_INSERT) && !full;

	always_comb begin
		if (ram_we) begin
			ram_addr = AW'(cnt_q);
		end else if (state_q == FSM_IDLE) begin
			ram_addr = '0;
		end else begin
			ram_addr = AW'(idx_inc);
		end
	end

	los_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (req.payload.value),
		.rdata (rd_data)
	);

	// Controller: state, fill count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				FSM_IDLE: begin
					if (req_acc) begin
						if (req.payload.kind == KIND_INSERT) begin
							rsp_valid_q <= 1'b1;
							if (!full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else if (cnt_q == '0) begin
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= FSM_SCAN;
						end
					end
				end
				FSM_SCAN: begin
					if (is_match) begin
						if (has_next) begin
							state_q <= FSM_SUCC;
						end else begin
							rsp_valid_q <= 1'b1;
							state_q     <= FSM_IDLE;
						end
					end else if (!has_next) begin
						rsp_valid_q <= 1'b1;
						state_q     <= FSM_IDLE;
					end
				end
				FSM_SUCC: begin
					rsp_valid_q <= 1'b1;
					state_q     <= FSM_IDLE;
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// Datapath: key, scan index, predecessor and the result register
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				if (req_acc) begin
					key_q <= req.payload.value;
					idx_q <= '0;
					if (req.payload.kind == KIND_INSERT) begin
						if (full) begin
							rsp_q <= plain_rsp(STAT_FULL, '0, POS_W'(cnt_q));
						end else begin
							rsp_q <= plain_rsp(STAT_OK, POS_W'(cnt_q + CW'(1)),
								POS_W'(cnt_q + CW'(1)));
						end
					end else if (cnt_q == '0) begin
						rsp_q <= plain_rsp(STAT_NOT_FOUND, '0, POS_W'(cnt_q));
					end
				end
			end
			FSM_SCAN: begin
				if (is_match) begin
					rsp_q.status     <= STAT_OK;
					rsp_q.position   <= POS_W'(idx_inc);
					rsp_q.has_pred   <= (idx_q != '0);
					rsp_q.pred_value <= (idx_q != '0) ? prev_q : '0;
					rsp_q.has_succ   <= has_next;
					rsp_q.succ_value <= '0;
					rsp_q.node_count <= POS_W'(cnt_q);
				end else begin
					prev_q <= rd_data;
					if (has_next) begin
						idx_q <= AW'(idx_inc);
					end else begin
						rsp_q <= plain_rsp(STAT_NOT_FOUND, '0, POS_W'(cnt_q));
					end
				end
			end
			FSM_SUCC: begin
				// Prefetched entry after the match
				rsp_q.succ_value <= rd_data;
			end
			default: begin
			end
		endcase
	end

	// Fill count stays within the store
	`LOS_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_q <= CW'(CAPACITY),
		"fill count exceeds capacity")

	// A search in progress never overlaps a pending result
	`LOS_ASSERT_NOW(a_busy_slot_free, state_q != FSM_IDLE, !rsp_valid_q,
		"result pending while search in progress")

	// Searches never change the fill count
	`LOS_ASSERT_NEXT(a_scan_cnt_stable, state_q != FSM_IDLE, $stable(cnt_q),
		"fill count changed during search")

endmodule
